>>> sv/path_pair_conflict_detector_defines.svh
// Assertion macros for the path pair conflict detector
`ifndef PATH_PAIR_CONFLICT_DETECTOR_DEFINES_SVH
`define PATH_PAIR_CONFLICT_DETECTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PPCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PPCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ppcd_pkg.sv
// Shared constants and types for the path pair conflict detector
package ppcd_pkg;

    localparam int LOC_BITS_DEF   = 16;
    localparam int AGENT_BITS_DEF = 10;
    localparam int TIME_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_VERTEX = 2'd1,
        KIND_EDGE   = 2'd2,
        KIND_GOAL   = 2'd3
    } kind_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctrl_t;

endpackage

>>> sv/ppcd_req_if.sv
// Input beat channel: two agents' locations for one timestep
interface ppcd_req_if #(
    parameter int LOC_BITS   = ppcd_pkg::LOC_BITS_DEF,
    parameter int AGENT_BITS = ppcd_pkg::AGENT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [AGENT_BITS-1:0] agent_first;
    logic [AGENT_BITS-1:0] agent_second;
    logic                  first_present;
    logic                  second_present;
    logic [LOC_BITS-1:0]   loc_first;
    logic [LOC_BITS-1:0]   loc_second;
    logic                  pair_last;

    modport source (
        output valid, agent_first, agent_second, first_present, second_present,
               loc_first, loc_second, pair_last,
        input  ready
    );

    modport sink (
        input  valid, agent_first, agent_second, first_present, second_present,
               loc_first, loc_second, pair_last,
        output ready
    );
endinterface

>>> sv/ppcd_rsp_if.sv
// Result beat channel: one conflict report
interface ppcd_rsp_if #(
    parameter int LOC_BITS   = ppcd_pkg::LOC_BITS_DEF,
    parameter int AGENT_BITS = ppcd_pkg::AGENT_BITS_DEF,
    parameter int TIME_BITS  = ppcd_pkg::TIME_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [AGENT_BITS-1:0] conflict_agent_a;
    logic [AGENT_BITS-1:0] conflict_agent_b;
    logic [LOC_BITS-1:0]   conflict_loc_a;
    logic [LOC_BITS-1:0]   conflict_loc_b;
    logic [TIME_BITS-1:0]  conflict_time;
    ppcd_pkg::kind_t       conflict_kind;
    logic                  pair_done;

    modport source (
        output valid, conflict_agent_a, conflict_agent_b, conflict_loc_a,
               conflict_loc_b, conflict_time, conflict_kind, pair_done,
        input  ready
    );

    modport sink (
        input  valid, conflict_agent_a, conflict_agent_b, conflict_loc_a,
               conflict_loc_b, conflict_time, conflict_kind, pair_done,
        output ready
    );
endinterface

>>> sv/ppcd_cfg_if.sv
// Configuration write channel for the goal wait enable
interface ppcd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );
endinterface

>>> sv/ppcd_in_stage.sv
// Input register stage holding one accepted timestep
module ppcd_in_stage #(
    parameter int LOC_BITS   = ppcd_pkg::LOC_BITS_DEF,
    parameter int AGENT_BITS = ppcd_pkg::AGENT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ppcd_req_if.sink              req,
    input  logic                  advance,
    output logic                  valid,
    output logic [AGENT_BITS-1:0] agent_first,
    output logic [AGENT_BITS-1:0] agent_second,
    output logic                  first_present,
    output logic                  second_present,
    output logic [LOC_BITS-1:0]   loc_first,
    output logic [LOC_BITS-1:0]   loc_second,
    output logic                  pair_last
);
    import ppcd_pkg::*;

    logic                  valid_reg;
    logic [AGENT_BITS-1:0] agent_first_reg;
    logic [AGENT_BITS-1:0] agent_second_reg;
    logic                  first_present_reg;
    logic                  second_present_reg;
    logic [LOC_BITS-1:0]   loc_first_reg;
    logic [LOC_BITS-1:0]   loc_second_reg;
    logic                  pair_last_reg;

    assign req.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            agent_first_reg    <= req.agent_first;
            agent_second_reg   <= req.agent_second;
            first_present_reg  <= req.first_present;
            second_present_reg <= req.second_present;
            loc_first_reg      <= req.loc_first;
            loc_second_reg     <= req.loc_second;
            pair_last_reg      <= req.pair_last;
        end
    end

    assign valid          = valid_reg;
    assign agent_first    = agent_first_reg;
    assign agent_second   = agent_second_reg;
    assign first_present  = first_present_reg;
    assign second_present = second_present_reg;
    assign loc_first      = loc_first_reg;
    assign loc_second     = loc_second_reg;
    assign pair_last      = pair_last_reg;
endmodule

>>> sv/ppcd_check.sv
// Conflict checks and per-pair state
module ppcd_check #(
    parameter int LOC_BITS  = ppcd_pkg::LOC_BITS_DEF,
    parameter int TIME_BITS = ppcd_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppcd_pkg::stage_ctrl_t ctrl,
    input  logic                  goal_wait,
    input  logic                  first_present,
    input  logic                  second_present,
    input  logic [LOC_BITS-1:0]   loc_first,
    input  logic [LOC_BITS-1:0]   loc_second,
    input  logic                  pair_last,
    output logic                  emit,
    output logic [LOC_BITS-1:0]   loc_a,
    output logic [LOC_BITS-1:0]   loc_b,
    output logic [TIME_BITS-1:0]  step,
    output ppcd_pkg::kind_t       kind
);
    import ppcd_pkg::*;

    logic                 fire;
    logic [TIME_BITS-1:0] step_reg;
    logic [TIME_BITS-1:0] step_next;
    logic [LOC_BITS-1:0]  prev_first_reg;
    logic [LOC_BITS-1:0]  prev_second_reg;
    logic                 have_prev_reg;
    logic                 main_done_reg;
    logic                 main_done_next;

    assign fire = ctrl.valid && ctrl.advance;

    always_comb
    begin
        kind           = KIND_NONE;
        loc_a          = '0;
        loc_b          = '0;
        main_done_next = main_done_reg;
        if (first_present && second_present)
        begin
            if (!main_done_reg)
            begin
                if (have_prev_reg && prev_first_reg == loc_second
                    && prev_second_reg == loc_first)
                begin
                    kind           = KIND_EDGE;
                    loc_a          = prev_first_reg;
                    loc_b          = prev_second_reg;
                    main_done_next = 1'b1;
                end
                else if (loc_first == loc_second)
                begin
                    kind           = KIND_VERTEX;
                    loc_a          = loc_first;
                    main_done_next = 1'b1;
                end
            end
        end
        else if (goal_wait && (first_present || second_present))
        begin
            if (first_present && loc_first == prev_second_reg)
            begin
                kind  = KIND_GOAL;
                loc_a = loc_first;
            end
            else if (second_present && loc_second == prev_first_reg)
            begin
                kind  = KIND_GOAL;
                loc_a = loc_second;
            end
        end
    end

    // saturate at the top of the range
    assign step_next = (step_reg == '1) ? step_reg : step_reg + TIME_BITS'(1);
    assign emit      = (kind != KIND_NONE) || pair_last;
    assign step      = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg        <= '0;
            prev_first_reg  <= '0;
            prev_second_reg <= '0;
            have_prev_reg   <= 1'b0;
            main_done_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (pair_last)
            begin
                step_reg        <= '0;
                prev_first_reg  <= '0;
                prev_second_reg <= '0;
                have_prev_reg   <= 1'b0;
                main_done_reg   <= 1'b0;
            end
            else
            begin
                step_reg      <= step_next;
                have_prev_reg <= first_present && second_present;
                main_done_reg <= main_done_next;
                if (first_present)
                begin
                    prev_first_reg <= loc_first;
                end
                if (second_present)
                begin
                    prev_second_reg <= loc_second;
                end
            end
        end
    end
endmodule

>>> sv/ppcd_out_stage.sv
// Result register stage driving the result channel
module ppcd_out_stage #(
    parameter int LOC_BITS   = ppcd_pkg::LOC_BITS_DEF,
    parameter int AGENT_BITS = ppcd_pkg::AGENT_BITS_DEF,
    parameter int TIME_BITS  = ppcd_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    input  logic                  emit,
    input  logic [AGENT_BITS-1:0] agent_first,
    input  logic [AGENT_BITS-1:0] agent_second,
    input  logic [LOC_BITS-1:0]   loc_a,
    input  logic [LOC_BITS-1:0]   loc_b,
    input  logic [TIME_BITS-1:0]  step,
    input  ppcd_pkg::kind_t       kind,
    input  logic                  pair_last,
    output logic                  advance,
    ppcd_rsp_if.source            rsp
);
    import ppcd_pkg::*;

    logic                  valid_reg;
    logic [AGENT_BITS-1:0] agent_a_reg;
    logic [AGENT_BITS-1:0] agent_b_reg;
    logic [LOC_BITS-1:0]   loc_a_reg;
    logic [LOC_BITS-1:0]   loc_b_reg;
    logic [TIME_BITS-1:0]  time_reg;
    kind_t                 kind_reg;
    logic                  done_reg;

    assign advance = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load_valid && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            agent_a_reg <= agent_first;
            agent_b_reg <= agent_second;
            loc_a_reg   <= loc_a;
            loc_b_reg   <= loc_b;
            time_reg    <= step;
            kind_reg    <= kind;
            done_reg    <= pair_last;
        end
    end

    assign rsp.valid            = valid_reg;
    assign rsp.conflict_agent_a = agent_a_reg;
    assign rsp.conflict_agent_b = agent_b_reg;
    assign rsp.conflict_loc_a   = loc_a_reg;
    assign rsp.conflict_loc_b   = loc_b_reg;
    assign rsp.conflict_time    = time_reg;
    assign rsp.conflict_kind    = kind_reg;
    assign rsp.pair_done        = done_reg;
endmodule

>>> sv/path_pair_conflict_detector.sv
// Top level of the path pair conflict detector
// Usage:
//   req carries one timestep of two agents' paths per beat: both locations,
//   their present flags and pair_last on the final timestep of the pair.
//   rsp carries at most one conflict report per req beat, in order; the
//   beat marked pair_last always yields a report with pair_done set.
//   cfg writes the goal wait enable (reset value 1); write it only while
//   the block is idle. cfg is always ready.
// Path: an accepted req beat is held in the input register; its report is
//   then registered in the result register, from which rsp is driven.
// Throughput: one req beat per cycle unless rsp is held off, set by a
//   single compare pass and step counter between input and result regs.
// Reset: clears both stages, the step counter, held locations and
//   conflict flags; goal wait checking comes up enabled.
// Stall: while rsp is held off the result register keeps its report and
//   the input register still takes one more beat, then req.ready drops;
//   that beat waits even if it gives no report.
`include "path_pair_conflict_detector_defines.svh"

module path_pair_conflict_detector #(
    parameter int LOC_BITS   = ppcd_pkg::LOC_BITS_DEF,
    parameter int AGENT_BITS = ppcd_pkg::AGENT_BITS_DEF,
    parameter int TIME_BITS  = ppcd_pkg::TIME_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ppcd_req_if.sink    req,
    ppcd_rsp_if.source  rsp,
    ppcd_cfg_if.sink    cfg
);
    import ppcd_pkg::*;

    logic                  goal_wait_reg;
    logic                  advance;
    logic                  s1_valid;
    logic [AGENT_BITS-1:0] s1_agent_first;
    logic [AGENT_BITS-1:0] s1_agent_second;
    logic                  s1_first_present;
    logic                  s1_second_present;
    logic [LOC_BITS-1:0]   s1_loc_first;
    logic [LOC_BITS-1:0]   s1_loc_second;
    logic                  s1_pair_last;
    stage_ctrl_t           ctrl;
    logic                  emit;
    logic [LOC_BITS-1:0]   loc_a;
    logic [LOC_BITS-1:0]   loc_b;
    logic [TIME_BITS-1:0]  step;
    kind_t                 kind;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_wait_reg <= 1'b1;
        end
        else if (cfg.valid && cfg.ready)
        begin
            goal_wait_reg <= cfg.data;
        end
    end

    ppcd_in_stage #(
        .LOC_BITS   (LOC_BITS),
        .AGENT_BITS (AGENT_BITS)
    ) u_in_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req),
        .advance        (advance),
        .valid          (s1_valid),
        .agent_first    (s1_agent_first),
        .agent_second   (s1_agent_second),
        .first_present  (s1_first_present),
        .second_present (s1_second_present),
        .loc_first      (s1_loc_first),
        .loc_second     (s1_loc_second),
        .pair_last      (s1_pair_last)
    );

    assign ctrl.valid   = s1_valid;
    assign ctrl.advance = advance;

    ppcd_check #(
        .LOC_BITS  (LOC_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .goal_wait      (goal_wait_reg),
        .first_present  (s1_first_present),
        .second_present (s1_second_present),
        .loc_first      (s1_loc_first),
        .loc_second     (s1_loc_second),
        .pair_last      (s1_pair_last),
        .emit           (emit),
        .loc_a          (loc_a),
        .loc_b          (loc_b),
        .step           (step),
        .kind           (kind)
    );

    ppcd_out_stage #(
        .LOC_BITS   (LOC_BITS),
        .AGENT_BITS (AGENT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_valid   (s1_valid),
        .emit         (emit),
        .agent_first  (s1_agent_first),
        .agent_second (s1_agent_second),
        .loc_a        (loc_a),
        .loc_b        (loc_b),
        .step         (step),
        .kind         (kind),
        .pair_last    (s1_pair_last),
        .advance      (advance),
        .rsp          (rsp)
    );

    `PPCD_ASSERT_NEXT(a_accept_fills, clk, rst_n, req.valid && req.ready, s1_valid, "accepted beat lost")
    `PPCD_ASSERT_NOW(a_last_emits, clk, rst_n, s1_valid && s1_pair_last, emit, "last beat without report")
    `PPCD_ASSERT_NEXT(a_last_reports, clk, rst_n, s1_valid && advance && s1_pair_last, rsp.valid && rsp.pair_done, "pair end report missing")
    `PPCD_ASSERT_NOW(a_none_is_end, clk, rst_n, rsp.valid && rsp.conflict_kind == KIND_NONE, rsp.pair_done, "empty report before pair end")
endmodule
